>>> src/cmr_pkg.sv
// Shared types, constants and the microcode program of the combined MLCG generator.
package cmr_pkg;

  // Request kinds carried on the input tuser field.
  localparam logic [1:0] REQ_DRAW = 2'd0;
  localparam logic [1:0] REQ_SEED = 2'd1;
  localparam logic [1:0] REQ_RAW  = 2'd2;

  // Multipliers, Schrage quotients and remainders, and moduli of both generators.
  localparam logic [15:0] GEN1_A = 16'd40014;
  localparam logic [15:0] GEN1_Q = 16'd53668;
  localparam logic [13:0] GEN1_R = 14'd12211;
  localparam logic [31:0] GEN1_M = 32'd2147483563;
  localparam logic [15:0] GEN2_A = 16'd40692;
  localparam logic [15:0] GEN2_Q = 16'd52774;
  localparam logic [13:0] GEN2_R = 14'd3791;
  localparam logic [31:0] GEN2_M = 32'd2147483399;

  // Reciprocals ceil(2^47 / Q): the quotient of a magnitude up to 2^31 is bits 62..47
  // of the product with the magnitude.
  localparam logic [31:0] GEN1_RCP = 32'd2622372520;
  localparam logic [31:0] GEN2_RCP = 32'd2666795929;

  // Seed derivation moduli and offsets.
  localparam logic [30:0] SMOD1 = 31'd2147483562;
  localparam logic [30:0] SMOD2 = 31'd2147483398;
  localparam logic [37:0] OFS1  = 38'h00_0000_feed;
  localparam logic [37:0] OFS2  = 38'h00_000d_efeb;

  // Distance of each seed modulus below 2^31, used to fold the high bits back in.
  localparam logic [7:0] SFOLD1 = 8'd86;
  localparam logic [7:0] SFOLD2 = 8'd250;

  // Wrap value for a combined output below one.
  localparam logic [31:0] ZWRAP = 32'd2147483562;

  // Reset values of the two generator seeds.
  localparam logic [31:0] GEN1_INIT = 32'h0000_abcd;
  localparam logic [31:0] GEN2_INIT = 32'h0000_1234;

  // Program entry points and steps.
  localparam logic [3:0] PC_DRAW      = 4'd0;
  localparam logic [3:0] PC_DRAW_QMUL = 4'd1;
  localparam logic [3:0] PC_DRAW_RMUL = 4'd2;
  localparam logic [3:0] PC_DRAW_MUL  = 4'd3;
  localparam logic [3:0] PC_DRAW_SUB  = 4'd4;
  localparam logic [3:0] PC_DRAW_FIX  = 4'd5;
  localparam logic [3:0] PC_DRAW_OUT  = 4'd6;
  localparam logic [3:0] PC_SEED      = 4'd7;
  localparam logic [3:0] PC_SEED_FOLD = 4'd8;
  localparam logic [3:0] PC_SEED_SUB  = 4'd9;
  localparam logic [3:0] PC_SEED_WR   = 4'd10;

  // One control word of the microcode program.
  typedef struct packed {
    logic ld_draw;
    logic ld_seed;
    logic qmul;
    logic rmul;
    logic mul;
    logic sub;
    logic fold;
    logic csub;
    logic wr_draw;
    logic wr_seed;
    logic out_ld;
    logic last;
  } ctl_t;

  // Microcode ROM.
  function automatic ctl_t ucode(input logic [3:0] pc);
    ctl_t c;
    c = '0;
    unique case (pc)
      PC_DRAW:      c.ld_draw = 1'b1;
      PC_DRAW_QMUL: c.qmul    = 1'b1;
      PC_DRAW_RMUL: c.rmul    = 1'b1;
      PC_DRAW_MUL:  c.mul     = 1'b1;
      PC_DRAW_SUB:  c.sub     = 1'b1;
      PC_DRAW_FIX:  c.wr_draw = 1'b1;
      PC_DRAW_OUT: begin
        c.out_ld = 1'b1;
        c.last   = 1'b1;
      end
      PC_SEED:      c.ld_seed = 1'b1;
      PC_SEED_FOLD: c.fold    = 1'b1;
      PC_SEED_SUB:  c.csub    = 1'b1;
      PC_SEED_WR: begin
        c.wr_seed = 1'b1;
        c.last    = 1'b1;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> src/combined_mlcg_random.sv
// Top level of the combined two-generator multiplicative congruential random source.
// A draw runs a seven-step program: its result is offered once the last step has loaded it, and
// the next request is taken only after the program has finished.
// A seed request runs 4 steps; raw loads and ignored requests start no program.
// A waiting result freezes a running program until it is taken. Synchronous active-low
// reset loads seeds 0xabcd and 0x1234, clears the seeded flag and empties the result.
module combined_mlcg_random (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // seed_value, fallback_seed, raw_first, raw_second
  input  logic [1:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // rand_value
);

  logic          busy;
  cmr_pkg::ctl_t ctl;
  logic          in_acc;
  logic          hold;
  logic          start;
  logic [3:0]    start_pc;
  logic [31:0]   seed_sel;
  logic          seed_go;

  logic [31:0]   gen1_r, gen1_nxt;
  logic [31:0]   gen2_r, gen2_nxt;
  logic          seeded_r, seeded_nxt;
  logic [31:0]   s_r;
  logic          out_vld_r, out_vld_nxt;
  logic [31:0]   out_dat_r;

  logic signed [37:0] s_ext;
  logic signed [37:0] ld1, ld2;
  logic [31:0]        draw1, draw2, seed1, seed2;
  logic signed [32:0] z;
  logic [32:0]        z_wrap;
  logic [31:0]        z_out;

  // Request decode and dispatch.
  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;
  assign seed_sel  = (in_tdata[31:0] == 32'd0) ? in_tdata[63:32] : in_tdata[31:0];
  assign seed_go   = (in_tuser == cmr_pkg::REQ_SEED) &&
                     ((in_tdata[31:0] != 32'd0) || !seeded_r);
  assign start     = in_acc && ((in_tuser == cmr_pkg::REQ_DRAW) || seed_go);
  assign start_pc  = (in_tuser == cmr_pkg::REQ_DRAW) ? cmr_pkg::PC_DRAW : cmr_pkg::PC_SEED;
  assign hold      = out_vld_r && !out_tready;

  cmr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .start_pc (start_pc),
    .hold     (hold),
    .busy     (busy),
    .ctl      (ctl)
  );

  // Lane operands: the current seed for a draw, the offset seed (times 32 in lane 2) for a derivation.
  assign s_ext = $signed({{6{s_r[31]}}, s_r});
  assign ld1   = ctl.ld_seed ? s_ext + $signed(cmr_pkg::OFS1)
                             : $signed({{6{gen1_r[31]}}, gen1_r});
  assign ld2   = ctl.ld_seed ? (s_ext + $signed(cmr_pkg::OFS2)) <<< 5
                             : $signed({{6{gen2_r[31]}}, gen2_r});

  cmr_lane u_lane1 (
    .clk      (clk),
    .ctl      (ctl),
    .ld_val   (ld1),
    .recip    (cmr_pkg::GEN1_RCP),
    .quot     (cmr_pkg::GEN1_Q),
    .mul_a    (cmr_pkg::GEN1_A),
    .mul_r    (cmr_pkg::GEN1_R),
    .mod_m    (cmr_pkg::GEN1_M),
    .fold_k   (cmr_pkg::SFOLD1),
    .smod     (cmr_pkg::SMOD1),
    .draw_res (draw1),
    .seed_res (seed1)
  );

  cmr_lane u_lane2 (
    .clk      (clk),
    .ctl      (ctl),
    .ld_val   (ld2),
    .recip    (cmr_pkg::GEN2_RCP),
    .quot     (cmr_pkg::GEN2_Q),
    .mul_a    (cmr_pkg::GEN2_A),
    .mul_r    (cmr_pkg::GEN2_R),
    .mod_m    (cmr_pkg::GEN2_M),
    .fold_k   (cmr_pkg::SFOLD2),
    .smod     (cmr_pkg::SMOD2),
    .draw_res (draw2),
    .seed_res (seed2)
  );

  // Combined value, wrapped into the positive range when it is below one.
  assign z      = $signed({gen1_r[31], gen1_r}) - $signed({gen2_r[31], gen2_r});
  assign z_wrap = 33'(z) + {1'b0, cmr_pkg::ZWRAP};
  assign z_out  = (z[32] || (z == 33'sd0)) ? z_wrap[31:0] : z[31:0];

  // Seed state updates from raw loads, derivations and draws.
  always_comb begin
    gen1_nxt   = gen1_r;
    gen2_nxt   = gen2_r;
    seeded_nxt = seeded_r;
    if (in_acc && (in_tuser == cmr_pkg::REQ_RAW)) begin
      gen1_nxt   = in_tdata[95:64];
      gen2_nxt   = in_tdata[127:96];
      seeded_nxt = 1'b1;
    end else if (ctl.wr_draw) begin
      gen1_nxt = draw1;
      gen2_nxt = draw2;
    end else if (ctl.wr_seed) begin
      gen1_nxt   = seed1;
      gen2_nxt   = seed2;
      seeded_nxt = 1'b1;
    end
  end

  // Result register: freed by the downstream request, loaded by the last draw step.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (ctl.out_ld) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen1_r    <= cmr_pkg::GEN1_INIT;
      gen2_r    <= cmr_pkg::GEN2_INIT;
      seeded_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      gen1_r    <= gen1_nxt;
      gen2_r    <= gen2_nxt;
      seeded_r  <= seeded_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc && seed_go) begin
      s_r <= seed_sel;
    end
    if (ctl.out_ld) begin
      out_dat_r <= z_out;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

endmodule

>>> src/cmr_seq.sv
// Microcode sequencer: program counter and control word fetch.
module cmr_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [3:0]    start_pc,
  input  logic          hold,
  output logic          busy,
  output cmr_pkg::ctl_t ctl
);

  logic          busy_r, busy_nxt;
  logic [3:0]    pc_r, pc_nxt;
  cmr_pkg::ctl_t rom_word;

  assign rom_word = cmr_pkg::ucode(pc_r);
  assign busy     = busy_r;
  // Steps act only while a program runs and the current step is not held.
  assign ctl      = (busy_r && !hold) ? rom_word : '0;

  // Next program counter and busy flag.
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = start_pc;
      end
    end else if (!hold) begin
      if (rom_word.last) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= cmr_pkg::PC_DRAW;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

>>> src/cmr_lane.sv
// One generator lane: reciprocal quotient, Schrage products, seed folding and fixups.
module cmr_lane (
  input  logic               clk,
  input  cmr_pkg::ctl_t      ctl,
  input  logic signed [37:0] ld_val,
  input  logic [31:0]        recip,
  input  logic [15:0]        quot,
  input  logic [15:0]        mul_a,
  input  logic [13:0]        mul_r,
  input  logic [31:0]        mod_m,
  input  logic [7:0]         fold_k,
  input  logic [30:0]        smod,
  output logic [31:0]        draw_res,
  output logic [31:0]        seed_res
);

  logic [37:0]        mag_r;
  logic [15:0]        quo_r;
  logic               neg_r;
  logic [31:0]        p1_r;
  logic [29:0]        p2_r;
  logic signed [33:0] t_r;

  logic [62:0]        qprod;
  logic [31:0]        qback;
  logic [14:0]        fprod;
  logic [37:0]        folded;
  logic               ge;
  logic signed [33:0] diff;
  logic [33:0]        t_wrap;

  // Quotient by reciprocal multiplication, exact for magnitudes up to 2^31.
  assign qprod  = {31'd0, mag_r[31:0]} * {31'd0, recip};
  assign qback  = {16'd0, quo_r} * {16'd0, quot};
  // The seed modulus is 2^31 minus the fold constant, so the bits above 2^31 fold back in.
  assign fprod  = {8'd0, mag_r[37:31]} * {7'd0, fold_k};
  assign folded = {7'd0, mag_r[30:0]} + {23'd0, fprod};
  assign ge     = mag_r >= {7'd0, smod};
  assign diff   = $signed({2'b00, p1_r}) - $signed({4'b0000, p2_r});

  // Load magnitude and sign, reduce it, then form the products and their difference.
  always_ff @(posedge clk) begin
    if (ctl.ld_draw || ctl.ld_seed) begin
      neg_r <= ld_val[37];
      mag_r <= ld_val[37] ? 38'(-ld_val) : 38'(ld_val);
    end else if (ctl.rmul) begin
      mag_r <= {6'd0, mag_r[31:0] - qback};
    end else if (ctl.fold) begin
      mag_r <= folded;
    end else if (ctl.csub && ge) begin
      mag_r <= mag_r - {7'd0, smod};
    end
    if (ctl.qmul) begin
      quo_r <= qprod[62:47];
    end
    if (ctl.mul) begin
      p1_r <= {16'd0, mul_a} * {16'd0, mag_r[15:0]};
      p2_r <= {16'd0, mul_r} * {14'd0, quo_r};
    end
    if (ctl.sub) begin
      t_r <= neg_r ? -diff : diff;
    end
  end

  // A negative Schrage result gets the modulus added once.
  assign t_wrap   = 34'(t_r) + {2'b00, mod_m};
  assign draw_res = t_r[33] ? t_wrap[31:0] : t_r[31:0];

  // Truncated remainder keeps the dividend's sign, then one is added.
  always_comb begin
    if (neg_r) begin
      seed_res = 32'(~mag_r + 38'd2);
    end else begin
      seed_res = 32'(mag_r + 38'd1);
    end
  end

endmodule

>>> src/cmr_check.sv
// Port-level checker for the combined MLCG generator, bound to the top level.
module cmr_check (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // A draw occupies the sequencer, so no request is taken in the next cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == cmr_pkg::REQ_DRAW) |=> !in_tready)
    else $error("request taken during a draw");

  // Every combined value lies between one and the wrap value.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != 32'd0) && (out_tdata <= cmr_pkg::ZWRAP))
    else $error("combined value out of range");

endmodule

bind combined_mlcg_random cmr_check u_cmr_check (.*);
